### hdl/rpwc_pkg.sv
// ----------------------------------------------------------------------------
// rpwc_pkg
// Shared types and constants for the RC pulse width capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpwc_pkg;

   // channel count default and fixed field widths
   localparam int CHANNELS_DEF = 6;
   localparam int FALL_W       = 6;
   localparam int PW_W         = 21;
   localparam int CH_W         = 3;
   localparam int SINCE_W      = 20;
   localparam int LEVEL_W      = 16;
   localparam int SCALE_W      = 17;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MAX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LINK_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_LEVEL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_LEVEL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_LOWER = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_UPPER = 3'd6;

   localparam logic [LEVEL_W-1:0] RANGE_MIN_RST    = 16'd900;
   localparam logic [LEVEL_W-1:0] RANGE_MAX_RST    = 16'd2100;
   localparam logic [SINCE_W-1:0] LINK_TIMEOUT_RST = 20'd1000000;
   localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST   = 16'd1900;
   localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST    = 16'd1100;
   localparam logic [LEVEL_W-1:0] MIDDLE_LOWER_RST = 16'd1400;
   localparam logic [LEVEL_W-1:0] MIDDLE_UPPER_RST = 16'd1600;

   localparam logic [SINCE_W-1:0]       SINCE_MAX   = {SINCE_W{1'b1}};
   localparam logic signed [PW_W-1:0]   WIDTH_UNSET = -21'sd1;

   // scaling: centred (w-1500)*4096/125, offset (w-1000)*2048/125
   localparam int DIFF_W = PW_W + 1;
   localparam logic signed [DIFF_W-1:0] CENTER_MID     = 22'sd1500;
   localparam logic signed [DIFF_W-1:0] CENTER_SAT     = 22'sd2000;
   localparam logic signed [DIFF_W-1:0] CENTER_SAT_NEG = -22'sd2000;
   localparam logic signed [DIFF_W-1:0] OFFSET_MID     = 22'sd1000;
   localparam logic signed [DIFF_W-1:0] OFFSET_SAT     = 22'sd4000;
   localparam logic signed [DIFF_W-1:0] OFFSET_SAT_NEG = -22'sd4000;

   // ceil(2^30/125): exact floor division for dividends below 2^23
   localparam int RECIP_W = 24;
   localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;
   localparam int CMAG_W  = 11;
   localparam int OMAG_W  = 12;
   localparam int C_SHIFT = 18;
   localparam int O_SHIFT = 19;

   localparam logic signed [SCALE_W-1:0] SAT_MAX = 17'sd65535;
   localparam logic signed [SCALE_W-1:0] SAT_MIN = -17'sd65536;

   typedef struct packed {
      logic [LEVEL_W-1:0] range_min;
      logic [LEVEL_W-1:0] range_max;
      logic [SINCE_W-1:0] link_timeout;
      logic [LEVEL_W-1:0] high_level;
      logic [LEVEL_W-1:0] low_level;
      logic [LEVEL_W-1:0] middle_lower;
      logic [LEVEL_W-1:0] middle_upper;
   } cfg_type;

   typedef struct packed {
      logic signed [PW_W-1:0] width;
      logic                   link_ok;
   } merge_type;

   typedef struct packed {
      logic signed [PW_W-1:0] width;
      logic                   link_ok;
      logic                   c_sat_hi;
      logic                   c_sat_lo;
      logic                   c_neg;
      logic [CMAG_W-1:0]      c_mag;
      logic                   o_sat_hi;
      logic                   o_sat_lo;
      logic                   o_neg;
      logic [OMAG_W-1:0]      o_mag;
      logic                   is_high;
      logic                   is_low;
      logic                   is_middle;
   } prep_type;

endpackage

`default_nettype wire

### hdl/rpwc_if.sv
// ----------------------------------------------------------------------------
// rpwc_if
// Request and response channels of the RC pulse width capture block.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpwc_req_if;
   import rpwc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   rise_edge;
   logic [FALL_W-1:0]      fall_edges;
   logic                   manual_write;
   logic signed [PW_W-1:0] manual_width;
   logic [CH_W-1:0]        channel;

   modport source (output valid, rise_edge, fall_edges, manual_write, manual_width, channel,
                   input ready);
   modport sink (input valid, rise_edge, fall_edges, manual_write, manual_width, channel,
                 output ready);
endinterface

interface rpwc_rsp_if;
   import rpwc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [PW_W-1:0]    pulse_width;
   logic signed [SCALE_W-1:0] centered_value;
   logic signed [SCALE_W-1:0] offset_value;
   logic                      is_high;
   logic                      is_low;
   logic                      is_middle;
   logic                      link_ok;

   modport source (output valid, pulse_width, centered_value, offset_value, is_high, is_low,
                   is_middle, link_ok, input ready);
   modport sink (input valid, pulse_width, centered_value, offset_value, is_high, is_low,
                 is_middle, link_ok, output ready);
endinterface

`default_nettype wire

### hdl/rpwc_lane.sv
// ----------------------------------------------------------------------------
// rpwc_lane
// One channel: width register with fall capture, manual override and a
// range check on the stored width.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwc_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic                             fall,
   input  logic                             manual_sel,
   input  logic signed [rpwc_pkg::PW_W-1:0] manual_width,
   input  logic [rpwc_pkg::SINCE_W-1:0]     since,
   input  logic [rpwc_pkg::LEVEL_W-1:0]     range_min,
   input  logic [rpwc_pkg::LEVEL_W-1:0]     range_max,
   output logic signed [rpwc_pkg::PW_W-1:0] width,
   output logic                             in_range
);
   import rpwc_pkg::*;

   logic signed [PW_W-1:0] width_ff;
   logic signed [PW_W-1:0] width_in;

   // manual write wins over a fall in the same word
   always_comb begin
      width_in = width_ff;
      if (load) begin
         priority if (manual_sel) begin
            width_in = manual_width;
         end else if (fall) begin
            width_in = $signed(PW_W'(since));
         end else begin
            width_in = width_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_UNSET;
      end else begin
         width_ff <= width_in;
      end
   end

   assign width    = width_ff;
   assign in_range = (width_ff >= $signed({5'b0, range_min}))
                  && (width_ff <= $signed({5'b0, range_max}));

endmodule

`default_nettype wire

### hdl/rpwc_merge.sv
// ----------------------------------------------------------------------------
// rpwc_merge
// Combines the lanes: picks the selected channel width and folds the range
// checks and the timeout into the link status.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwc_merge #(
   parameter int CHANNELS = rpwc_pkg::CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [rpwc_pkg::CH_W-1:0]        channel,
   input  logic signed [rpwc_pkg::PW_W-1:0] widths [CHANNELS],
   input  logic [CHANNELS-1:0]              in_range,
   input  logic [rpwc_pkg::SINCE_W-1:0]     since,
   input  rpwc_pkg::cfg_type                cfg,
   output logic                             out_valid,
   input  logic                             out_ready,
   output rpwc_pkg::merge_type              out_data
);
   import rpwc_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   merge_type data_ff;
   merge_type data_in;
   logic      take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // a channel with no lane reads as never captured
   always_comb begin
      data_in.width = WIDTH_UNSET;
      for (int i = 0; i < CHANNELS; i++) begin
         if (32'(channel) == 32'(i)) begin
            data_in.width = widths[i];
         end
      end
      data_in.link_ok = (since < cfg.link_timeout) && (&in_range);
   end

   assign valid_in = take || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### hdl/rpwc_scale.sv
// ----------------------------------------------------------------------------
// rpwc_scale
// Threshold flags and the two saturated Q14 scalings, two stages ending in
// the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwc_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rpwc_pkg::merge_type in_data,
   input  rpwc_pkg::cfg_type   cfg,
   rpwc_rsp_if.source          rsp
);
   import rpwc_pkg::*;

   logic     prep_valid_ff;
   logic     prep_valid_in;
   prep_type prep_ff;
   prep_type prep_in;
   logic     prep_ready;
   logic     prep_take;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      out_ready;
   logic signed [PW_W-1:0]    pulse_width_ff;
   logic signed [SCALE_W-1:0] centered_ff;
   logic signed [SCALE_W-1:0] centered_in;
   logic signed [SCALE_W-1:0] offset_ff;
   logic signed [SCALE_W-1:0] offset_in;
   logic                      is_high_ff;
   logic                      is_low_ff;
   logic                      is_middle_ff;
   logic                      link_ok_ff;

   logic signed [DIFF_W-1:0]     diff_c;
   logic signed [DIFF_W-1:0]     diff_o;
   logic [DIFF_W-1:0]            abs_c;
   logic [DIFF_W-1:0]            abs_o;
   logic [CMAG_W+RECIP_W-1:0]    prod_c;
   logic [OMAG_W+RECIP_W-1:0]    prod_o;
   logic [SCALE_W-1:0]           quot_c;
   logic [SCALE_W-1:0]           quot_o;

   assign out_ready  = !out_valid_ff || rsp.ready;
   assign prep_ready = !prep_valid_ff || out_ready;
   assign in_ready   = prep_ready;
   assign prep_take  = in_valid && prep_ready;

   // differences, saturation tests and magnitudes
   always_comb begin
      diff_c = DIFF_W'(in_data.width) - CENTER_MID;
      diff_o = DIFF_W'(in_data.width) - OFFSET_MID;
      abs_c  = diff_c[DIFF_W-1] ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
      abs_o  = diff_o[DIFF_W-1] ? DIFF_W'(-diff_o) : DIFF_W'(diff_o);

      prep_in.width     = in_data.width;
      prep_in.link_ok   = in_data.link_ok;
      prep_in.c_sat_hi  = diff_c >= CENTER_SAT;
      prep_in.c_sat_lo  = diff_c <= CENTER_SAT_NEG;
      prep_in.c_neg     = diff_c[DIFF_W-1];
      prep_in.c_mag     = abs_c[CMAG_W-1:0];
      prep_in.o_sat_hi  = diff_o >= OFFSET_SAT;
      prep_in.o_sat_lo  = diff_o <= OFFSET_SAT_NEG;
      prep_in.o_neg     = diff_o[DIFF_W-1];
      prep_in.o_mag     = abs_o[OMAG_W-1:0];
      prep_in.is_high   = in_data.width > $signed({5'b0, cfg.high_level});
      prep_in.is_low    = in_data.width < $signed({5'b0, cfg.low_level});
      prep_in.is_middle = (in_data.width > $signed({5'b0, cfg.middle_lower}))
                       && (in_data.width < $signed({5'b0, cfg.middle_upper}));
   end

   assign prep_valid_in = prep_take || (prep_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= prep_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_take) begin
         prep_ff <= prep_in;
      end
   end

   // division by 125 as a reciprocal multiply, truncation toward zero via magnitude
   always_comb begin
      prod_c = (CMAG_W+RECIP_W)'(prep_ff.c_mag) * (CMAG_W+RECIP_W)'(RECIP_125);
      prod_o = (OMAG_W+RECIP_W)'(prep_ff.o_mag) * (OMAG_W+RECIP_W)'(RECIP_125);
      quot_c = prod_c[CMAG_W+RECIP_W-1:C_SHIFT];
      quot_o = prod_o[OMAG_W+RECIP_W-1:O_SHIFT];

      priority if (prep_ff.c_sat_hi) begin
         centered_in = SAT_MAX;
      end else if (prep_ff.c_sat_lo) begin
         centered_in = SAT_MIN;
      end else if (prep_ff.c_neg) begin
         centered_in = SCALE_W'(-$signed(quot_c));
      end else begin
         centered_in = $signed(quot_c);
      end

      priority if (prep_ff.o_sat_hi) begin
         offset_in = SAT_MAX;
      end else if (prep_ff.o_sat_lo) begin
         offset_in = SAT_MIN;
      end else if (prep_ff.o_neg) begin
         offset_in = SCALE_W'(-$signed(quot_o));
      end else begin
         offset_in = $signed(quot_o);
      end
   end

   assign out_valid_in = (prep_valid_ff && out_ready) || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_valid_ff && out_ready) begin
         pulse_width_ff <= prep_ff.width;
         centered_ff    <= centered_in;
         offset_ff      <= offset_in;
         is_high_ff     <= prep_ff.is_high;
         is_low_ff      <= prep_ff.is_low;
         is_middle_ff   <= prep_ff.is_middle;
         link_ok_ff     <= prep_ff.link_ok;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.pulse_width    = pulse_width_ff;
   assign rsp.centered_value = centered_ff;
   assign rsp.offset_value   = offset_ff;
   assign rsp.is_high        = is_high_ff;
   assign rsp.is_low         = is_low_ff;
   assign rsp.is_middle      = is_middle_ff;
   assign rsp.link_ok        = link_ok_ff;

endmodule

`default_nettype wire

### hdl/rc_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture
// Takes one word per microsecond tick, every cycle while not stalled, with no
// gaps needed. A word updates the saturating since-rise counter and all
// channel lanes in the cycle it is accepted, so the next word may follow in
// the very next cycle. Its response passes four registers: lane update,
// channel select and link merge, flag and scaling set-up, then the reciprocal
// multiply into the response register. A stalled response backs up through
// the four stages before the request side stops taking words.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_width_capture #(
   parameter int CHANNELS = rpwc_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   rpwc_req_if.sink                            req,
   rpwc_rsp_if.source                          rsp,
   input  logic                                csr_write_en,
   input  logic [rpwc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rpwc_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import rpwc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic [SINCE_W-1:0] since_ff;
   logic [SINCE_W-1:0] since_in;
   logic [SINCE_W-1:0] since_next;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic [CH_W-1:0] s1_channel_ff;
   logic            merge_ready;
   logic            accept;

   logic signed [PW_W-1:0] lane_width [CHANNELS];
   logic [CHANNELS-1:0]    lane_in_range;

   logic      merge_valid;
   logic      scale_ready;
   merge_type merge_data;

   assign req.ready = !s1_valid_ff || merge_ready;
   assign accept    = req.valid && req.ready;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_RANGE_MIN:    cfg_in.range_min    = csr_write_data[LEVEL_W-1:0];
            REG_RANGE_MAX:    cfg_in.range_max    = csr_write_data[LEVEL_W-1:0];
            REG_LINK_TIMEOUT: cfg_in.link_timeout = csr_write_data[SINCE_W-1:0];
            REG_HIGH_LEVEL:   cfg_in.high_level   = csr_write_data[LEVEL_W-1:0];
            REG_LOW_LEVEL:    cfg_in.low_level    = csr_write_data[LEVEL_W-1:0];
            REG_MIDDLE_LOWER: cfg_in.middle_lower = csr_write_data[LEVEL_W-1:0];
            REG_MIDDLE_UPPER: cfg_in.middle_upper = csr_write_data[LEVEL_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min    <= RANGE_MIN_RST;
         cfg_ff.range_max    <= RANGE_MAX_RST;
         cfg_ff.link_timeout <= LINK_TIMEOUT_RST;
         cfg_ff.high_level   <= HIGH_LEVEL_RST;
         cfg_ff.low_level    <= LOW_LEVEL_RST;
         cfg_ff.middle_lower <= MIDDLE_LOWER_RST;
         cfg_ff.middle_upper <= MIDDLE_UPPER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // microsecond counter, restarts on rise and sticks at all ones
   always_comb begin
      priority if (req.rise_edge) begin
         since_next = '0;
      end else if (since_ff != SINCE_MAX) begin
         since_next = since_ff + 1'b1;
      end else begin
         since_next = since_ff;
      end
      since_in = accept ? since_next : since_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff <= SINCE_MAX;
      end else begin
         since_ff <= since_in;
      end
   end

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic fall;
      logic manual_sel;

      if (i < FALL_W) begin : g_fall
         assign fall = req.fall_edges[i];
      end else begin : g_no_fall
         assign fall = 1'b0;
      end

      assign manual_sel = req.manual_write && (32'(req.channel) == 32'(i));

      rpwc_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .load         (accept),
         .fall         (fall),
         .manual_sel   (manual_sel),
         .manual_width (req.manual_width),
         .since        (since_next),
         .range_min    (cfg_ff.range_min),
         .range_max    (cfg_ff.range_max),
         .width        (lane_width[i]),
         .in_range     (lane_in_range[i])
      );
   end

   // lane registers hold the post-update state while the word sits here
   assign s1_valid_in = accept || (s1_valid_ff && !merge_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_channel_ff <= req.channel;
      end
   end

   rpwc_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (merge_ready),
      .channel   (s1_channel_ff),
      .widths    (lane_width),
      .in_range  (lane_in_range),
      .since     (since_ff),
      .cfg       (cfg_ff),
      .out_valid (merge_valid),
      .out_ready (scale_ready),
      .out_data  (merge_data)
   );

   rpwc_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (merge_valid),
      .in_ready (scale_ready),
      .in_data  (merge_data),
      .cfg      (cfg_ff),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   a_rise_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.rise_edge |=> since_ff == '0)
      else $error("since-rise counter not cleared by rise");

   a_manual_lane0: assert property (@(posedge clock) disable iff (reset)
      accept && req.manual_write && (req.channel == '0)
      |=> lane_width[0] == $past(req.manual_width))
      else $error("manual write not stored in lane 0");

   a_centered_sign: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.centered_value[SCALE_W-1] == (rsp.pulse_width < 21'sd1500)))
      else $error("centred value sign disagrees with width");

   a_offset_sign: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.offset_value[SCALE_W-1] == (rsp.pulse_width < 21'sd1000)))
      else $error("offset value sign disagrees with width");
`endif

endmodule

`default_nettype wire
